// ===== rtl/core/rrcm_pkg.sv =====
// Package for the ray-ray closest midpoint block: coordinate width,
// multiplier digit size and the beat types of both channels.
// No dependencies.
package rrcm_pkg;

  localparam int COORD_WIDTH = 32;
  // Operand digit that one multiplier stage consumes.
  localparam int MUL_DIGIT = 16;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_origin_x;
    logic signed [COORD_WIDTH-1:0] first_origin_y;
    logic signed [COORD_WIDTH-1:0] first_origin_z;
    logic signed [COORD_WIDTH-1:0] first_dir_x;
    logic signed [COORD_WIDTH-1:0] first_dir_y;
    logic signed [COORD_WIDTH-1:0] first_dir_z;
    logic signed [COORD_WIDTH-1:0] second_origin_x;
    logic signed [COORD_WIDTH-1:0] second_origin_y;
    logic signed [COORD_WIDTH-1:0] second_origin_z;
    logic signed [COORD_WIDTH-1:0] second_dir_x;
    logic signed [COORD_WIDTH-1:0] second_dir_y;
    logic signed [COORD_WIDTH-1:0] second_dir_z;
  } rrcm_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] mid_x;
    logic signed [COORD_WIDTH-1:0] mid_y;
    logic signed [COORD_WIDTH-1:0] mid_z;
    logic                          lines_parallel;
  } rrcm_out_t;

endpackage

// ===== rtl/core/rrcm_mul.sv =====
// Pipelined signed multiplier, one digit of b per register stage.
// Depends on rrcm_pkg for default sizes.
module rrcm_mul #(
  parameter int WA  = rrcm_pkg::COORD_WIDTH + 1,
  parameter int WB  = rrcm_pkg::COORD_WIDTH + 1,
  parameter int DIG = rrcm_pkg::MUL_DIGIT
) (
  input  logic                    clk,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int ND  = (WB + DIG - 1) / DIG;
  localparam int WBX = ND * DIG;
  localparam int PW  = WA + WB;
  localparam int PPW = WA + DIG + 1;

  logic signed [WA-1:0]  a_r   [ND];
  logic signed [WBX-1:0] b_r   [ND];
  logic signed [PW-1:0]  acc_r [ND];

  for (genvar i = 0; i < ND; i++) begin : g_st
    logic signed [WA-1:0]  a_in;
    logic signed [WBX-1:0] b_in;
    logic signed [PW-1:0]  acc_in;
    logic signed [PPW-1:0] dig;
    logic signed [PPW-1:0] pp;

    if (i == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = WBX'(b);
      assign acc_in = '0;
    end else begin : g_rest
      assign a_in   = a_r[i-1];
      assign b_in   = b_r[i-1];
      assign acc_in = acc_r[i-1];
    end

    // top digit carries the sign, the others are unsigned
    if (i == ND - 1) begin : g_top
      assign dig = PPW'($signed(b_in[i*DIG +: DIG]));
    end else begin : g_low
      assign dig = PPW'($signed({1'b0, b_in[i*DIG +: DIG]}));
    end

    assign pp = PPW'(a_in) * dig;

    always_ff @(posedge clk) begin
      a_r[i]   <= a_in;
      b_r[i]   <= b_in;
      acc_r[i] <= acc_in + (PW'(pp) <<< (i * DIG));
    end
  end

  assign p = acc_r[ND-1];

endmodule

// ===== rtl/core/ray_ray_closest_midpoint.sv =====
// Top level: closest-approach midpoint of two 3D lines, fixed point.
// Depends on rrcm_pkg and rrcm_mul.
//
// channel  dir  handshake       beat
// -------  ---  --------------  ----------------------------
// item     in   start & !busy   rrcm_in_t, two rays O/D
// result   out  done strobe     rrcm_out_t, midpoint + flag
//
// Fully pipelined: a new beat is taken every cycle (busy is always low).
// The restoring divider (one quotient bit per stage) is most of the pipe.
// Reset clears only the valid chain; data registers run free.
// The receiver cannot stall, so nothing in the pipe ever waits.
module ray_ray_closest_midpoint (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rrcm_pkg::rrcm_in_t  item,
  output logic                done,
  output rrcm_pkg::rrcm_out_t result
);
  import rrcm_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DIG  = MUL_DIGIT;
  localparam int XW1  = W + 1;             // extended coords, sums, diffs
  localparam int M1   = (XW1 + DIG - 1) / DIG;
  localparam int PW1  = 2 * XW1;
  localparam int DW   = PW1 + 2;           // dot products
  localparam int M2   = (DW + DIG - 1) / DIG;
  localparam int PW2  = 2 * DW;
  localparam int EW   = PW2 + 1;           // det, s and t numerators
  localparam int M3   = (EW + DIG - 1) / DIG;
  localparam int PW3  = EW + XW1;
  localparam int NUMW = PW3 + 2;           // midpoint numerator
  localparam int XW   = NUMW + 3;          // divider width
  localparam int DL1  = M1 + M2 + 2;       // prep -> third multiplier rank
  localparam int DL2  = M3 + 1;            // det -> abs stage
  localparam int LAT  = 8 + M1 + M2 + M3 + W;
  localparam logic [W:0] HALF = (W + 1)'(1) << (W - 1);

  assign busy = 1'b0;

  // valid chain
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end
  assign done = vld[LAT-1];

  // input register and prep (O0-O1, O0+O1, widened directions)
  rrcm_in_t item_r;
  always_ff @(posedge clk) begin
    item_r <= item;
  end

  logic signed [W-1:0]   o0_c [3], o1_c [3], d0_c [3], d1_c [3];
  logic signed [XW1-1:0] d0 [3], d1 [3], r [3], s [3];

  assign o0_c[0] = item_r.first_origin_x;
  assign o0_c[1] = item_r.first_origin_y;
  assign o0_c[2] = item_r.first_origin_z;
  assign o1_c[0] = item_r.second_origin_x;
  assign o1_c[1] = item_r.second_origin_y;
  assign o1_c[2] = item_r.second_origin_z;
  assign d0_c[0] = item_r.first_dir_x;
  assign d0_c[1] = item_r.first_dir_y;
  assign d0_c[2] = item_r.first_dir_z;
  assign d1_c[0] = item_r.second_dir_x;
  assign d1_c[1] = item_r.second_dir_y;
  assign d1_c[2] = item_r.second_dir_z;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d0[k] <= XW1'($signed(d0_c[k]));
      d1[k] <= XW1'($signed(d1_c[k]));
      r[k]  <= XW1'($signed(o0_c[k])) - XW1'($signed(o1_c[k]));
      s[k]  <= XW1'($signed(o0_c[k])) + XW1'($signed(o1_c[k]));
    end
  end

  // carry s, d0, d1 to the third multiplier rank
  logic signed [XW1-1:0] s_dl [3][DL1], d0_dl [3][DL1], d1_dl [3][DL1];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s_dl[k][0]  <= s[k];
      d0_dl[k][0] <= d0[k];
      d1_dl[k][0] <= d1[k];
      for (int j = 1; j < DL1; j++) begin
        s_dl[k][j]  <= s_dl[k][j-1];
        d0_dl[k][j] <= d0_dl[k][j-1];
        d1_dl[k][j] <= d1_dl[k][j-1];
      end
    end
  end

  // rank 1: per-axis terms of a, b, e, c, f
  logic signed [PW1-1:0] p_a [3], p_b [3], p_e [3], p_c [3], p_f [3];
  for (genvar k = 0; k < 3; k++) begin : g_m1
    rrcm_mul #(.WA(XW1), .WB(XW1), .DIG(DIG)) u_a (.clk, .a(d0[k]), .b(d0[k]), .p(p_a[k]));
    rrcm_mul #(.WA(XW1), .WB(XW1), .DIG(DIG)) u_b (.clk, .a(d0[k]), .b(d1[k]), .p(p_b[k]));
    rrcm_mul #(.WA(XW1), .WB(XW1), .DIG(DIG)) u_e (.clk, .a(d1[k]), .b(d1[k]), .p(p_e[k]));
    rrcm_mul #(.WA(XW1), .WB(XW1), .DIG(DIG)) u_c (.clk, .a(d0[k]), .b(r[k]),  .p(p_c[k]));
    rrcm_mul #(.WA(XW1), .WB(XW1), .DIG(DIG)) u_f (.clk, .a(d1[k]), .b(r[k]),  .p(p_f[k]));
  end

  logic signed [DW-1:0] dot_a, dot_b, dot_e, dot_c, dot_f;
  always_ff @(posedge clk) begin
    dot_a <= DW'(p_a[0]) + DW'(p_a[1]) + DW'(p_a[2]);
    dot_b <= DW'(p_b[0]) + DW'(p_b[1]) + DW'(p_b[2]);
    dot_e <= DW'(p_e[0]) + DW'(p_e[1]) + DW'(p_e[2]);
    dot_c <= DW'(p_c[0]) + DW'(p_c[1]) + DW'(p_c[2]);
    dot_f <= DW'(p_f[0]) + DW'(p_f[1]) + DW'(p_f[2]);
  end

  // rank 2: det = ae - bb, ns = bf - ce, nt = af - bc
  logic signed [PW2-1:0] q_ae, q_bb, q_bf, q_ce, q_af, q_bc;
  rrcm_mul #(.WA(DW), .WB(DW), .DIG(DIG)) u_ae (.clk, .a(dot_a), .b(dot_e), .p(q_ae));
  rrcm_mul #(.WA(DW), .WB(DW), .DIG(DIG)) u_bb (.clk, .a(dot_b), .b(dot_b), .p(q_bb));
  rrcm_mul #(.WA(DW), .WB(DW), .DIG(DIG)) u_bf (.clk, .a(dot_b), .b(dot_f), .p(q_bf));
  rrcm_mul #(.WA(DW), .WB(DW), .DIG(DIG)) u_ce (.clk, .a(dot_c), .b(dot_e), .p(q_ce));
  rrcm_mul #(.WA(DW), .WB(DW), .DIG(DIG)) u_af (.clk, .a(dot_a), .b(dot_f), .p(q_af));
  rrcm_mul #(.WA(DW), .WB(DW), .DIG(DIG)) u_bc (.clk, .a(dot_b), .b(dot_c), .p(q_bc));

  logic signed [EW-1:0] det, ns, nt;
  always_ff @(posedge clk) begin
    det <= EW'(q_ae) - EW'(q_bb);
    ns  <= EW'(q_bf) - EW'(q_ce);
    nt  <= EW'(q_af) - EW'(q_bc);
  end

  logic signed [EW-1:0] det_dl [DL2];
  always_ff @(posedge clk) begin
    det_dl[0] <= det;
    for (int j = 1; j < DL2; j++) begin
      det_dl[j] <= det_dl[j-1];
    end
  end

  // rank 3: num = S*det + D0*ns + D1*nt per axis; the wide operand is
  // split into digits so each stage multiplies 33 by 17 bits
  logic signed [PW3-1:0] u_s [3], u_d0 [3], u_d1 [3];
  logic signed [NUMW-1:0] num [3];
  for (genvar k = 0; k < 3; k++) begin : g_m3
    rrcm_mul #(.WA(XW1), .WB(EW), .DIG(DIG)) u_sd
      (.clk, .a(s_dl[k][DL1-1]),  .b(det), .p(u_s[k]));
    rrcm_mul #(.WA(XW1), .WB(EW), .DIG(DIG)) u_d0n
      (.clk, .a(d0_dl[k][DL1-1]), .b(ns),  .p(u_d0[k]));
    rrcm_mul #(.WA(XW1), .WB(EW), .DIG(DIG)) u_d1n
      (.clk, .a(d1_dl[k][DL1-1]), .b(nt),  .p(u_d1[k]));

    always_ff @(posedge clk) begin
      num[k] <= NUMW'(u_s[k]) + NUMW'(u_d0[k]) + NUMW'(u_d1[k]);
    end
  end

  // divider stages: index 0 is the overflow check, then one bit per stage.
  // Round half up: floor((2*num + 2*det) / (4*det)); det is never negative.
  logic [XW-1:0] rem [3][W+1];
  logic [W-1:0]  quo [3][W+1];
  logic          neg [3][W+1];
  logic          ovf [3][W+1];
  logic [XW-1:0] dv  [W+1];
  logic          par [W+1];

  logic [XW-1:0] nmag [3];
  logic          nneg [3];
  logic [XW-1:0] dv_a;
  logic          par_a;

  for (genvar k = 0; k < 3; k++) begin : g_abs
    logic signed [XW-1:0] nval;
    assign nval = (XW'(num[k]) <<< 1) + (XW'(det_dl[DL2-1]) <<< 1);
    always_ff @(posedge clk) begin
      nneg[k] <= nval[XW-1];
      nmag[k] <= nval[XW-1] ? XW'(-nval) : XW'(nval);
    end
  end

  always_ff @(posedge clk) begin
    dv_a  <= XW'(det_dl[DL2-1]) << 2;
    par_a <= (det_dl[DL2-1] == '0);
  end

  always_ff @(posedge clk) begin
    dv[0]  <= dv_a;
    par[0] <= par_a;
  end

  for (genvar k = 0; k < 3; k++) begin : g_div0
    always_ff @(posedge clk) begin
      rem[k][0] <= nmag[k];
      quo[k][0] <= '0;
      neg[k][0] <= nneg[k];
      ovf[k][0] <= (nmag[k] >= (dv_a << W));
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int B = W - 1 - j;
    logic [XW-1:0] sh;
    assign sh = dv[j] << B;

    always_ff @(posedge clk) begin
      dv[j+1]  <= dv[j];
      par[j+1] <= par[j];
    end

    for (genvar k = 0; k < 3; k++) begin : g_ax
      always_ff @(posedge clk) begin
        neg[k][j+1] <= neg[k][j];
        ovf[k][j+1] <= ovf[k][j];
        if (rem[k][j] >= sh) begin
          rem[k][j+1]    <= rem[k][j] - sh;
          quo[k][j+1]    <= quo[k][j] | (W'(1) << B);
        end else begin
          rem[k][j+1]    <= rem[k][j];
          quo[k][j+1]    <= quo[k][j];
        end
      end
    end
  end

  // sign fix, saturation, parallel override
  logic signed [W-1:0] mid [3];
  for (genvar k = 0; k < 3; k++) begin : g_fin
    logic [W:0] mag;
    assign mag = {1'b0, quo[k][W]} + (W + 1)'(rem[k][W] != '0);
    always_comb begin
      if (par[W]) begin
        mid[k] = '0;
      end else if (neg[k][W]) begin
        if (ovf[k][W] || mag > HALF) begin
          mid[k] = {1'b1, {(W-1){1'b0}}};
        end else begin
          mid[k] = W'(-mag);
        end
      end else begin
        if (ovf[k][W] || quo[k][W][W-1]) begin
          mid[k] = {1'b0, {(W-1){1'b1}}};
        end else begin
          mid[k] = quo[k][W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    result.mid_x          <= mid[0];
    result.mid_y          <= mid[1];
    result.mid_z          <= mid[2];
    result.lines_parallel <= par[W];
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench for ray_ray_closest_midpoint: directed table plus random ray pairs,
// checked beat by beat against an exact wide-integer midpoint predictor.
// Depends on rrcm_pkg and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrcm_pkg::*;

  // 320 bits holds every exact intermediate (products reach ~170 bits)
  typedef logic signed [319:0] wide_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam int     NUM_RANDOM = 1150;
  localparam int     CALM_TAIL  = 150;   // last random beats go without gaps
  localparam int     DRAIN_WAIT = 80;    // extra wait once the queue is empty
  localparam int     CYCLE_CAP  = 200000;
  localparam coord_t ONE        = 32'sh0001_0000;
  localparam coord_t CMAX       = 32'sh7fff_ffff;
  localparam coord_t CMIN       = -32'sh7fff_ffff - 1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  logic      done;
  rrcm_in_t  item = '0;
  rrcm_out_t result;

  rrcm_out_t midpoints_due[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;

  ray_ray_closest_midpoint i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Exact closest-approach midpoint. det = |D0|^2|D1|^2 - (D0.D1)^2 is never
  // negative, so the divisor 4*det is positive whenever it is used.
  function automatic rrcm_out_t closest_midpoint(rrcm_in_t r);
    wide_t     o0[3], d0[3], o1[3], d1[3], rv[3];
    wide_t     a, b, c, e, f, det, ns, nt, num, den, q;
    rrcm_out_t m;
    m = '0;
    o0[0] = $signed(r.first_origin_x);  o0[1] = $signed(r.first_origin_y);
    o0[2] = $signed(r.first_origin_z);
    d0[0] = $signed(r.first_dir_x);     d0[1] = $signed(r.first_dir_y);
    d0[2] = $signed(r.first_dir_z);
    o1[0] = $signed(r.second_origin_x); o1[1] = $signed(r.second_origin_y);
    o1[2] = $signed(r.second_origin_z);
    d1[0] = $signed(r.second_dir_x);    d1[1] = $signed(r.second_dir_y);
    d1[2] = $signed(r.second_dir_z);
    a = 0; b = 0; c = 0; e = 0; f = 0;
    for (int k = 0; k < 3; k++) begin
      rv[k] = o0[k] - o1[k];
      a += d0[k] * d0[k];
      b += d0[k] * d1[k];
      e += d1[k] * d1[k];
      c += d0[k] * rv[k];
      f += d1[k] * rv[k];
    end
    det = a * e - b * b;
    if (det == 0) begin
      m.lines_parallel = 1'b1;
      return m;
    end
    ns  = b * f - c * e;
    nt  = a * f - b * c;
    den = 4 * det;
    for (int k = 0; k < 3; k++) begin
      // round half up: floor((2*num + 2*det) / (4*det))
      num = 2 * ((o0[k] + o1[k]) * det + d0[k] * ns + d1[k] * nt) + 2 * det;
      q = num / den;
      if (num < 0 && (num % den) != 0) q -= 1;
      if (q > wide_t'(CMAX)) q = wide_t'(CMAX);
      else if (q < wide_t'(CMIN)) q = wide_t'(CMIN);
      case (k)
        0: m.mid_x = q[COORD_WIDTH-1:0];
        1: m.mid_y = q[COORD_WIDTH-1:0];
        default: m.mid_z = q[COORD_WIDTH-1:0];
      endcase
    end
    return m;
  endfunction

  // Present one beat from the falling edge, hold until it is taken, then
  // queue what the block owes for it.
  task automatic send_rays(rrcm_in_t r, rrcm_out_t want);
    start <= 1'b1;
    item  <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    midpoints_due.push_back(want);
    @(negedge clk);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 4)) @(negedge clk);
  endtask

  function automatic rrcm_in_t make_rays(coord_t ox0, coord_t oy0, coord_t oz0,
                                         coord_t dx0, coord_t dy0, coord_t dz0,
                                         coord_t ox1, coord_t oy1, coord_t oz1,
                                         coord_t dx1, coord_t dy1, coord_t dz1);
    rrcm_in_t r;
    r = '{ox0, oy0, oz0, dx0, dy0, dz0, ox1, oy1, oz1, dx1, dy1, dz1};
    return r;
  endfunction

  function automatic coord_t rand_coord(int shape);
    case (shape)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
      2: return ($urandom_range(0, 1)) ? CMAX : CMIN;
      default: return coord_t'($signed($urandom_range(0, 6)) - 3) * ONE;
    endcase
  endfunction

  // Random pair. Half are general lines; the rest are exactly parallel,
  // near-parallel (drives saturation), zero-length or at the extremes.
  function automatic rrcm_in_t random_rays();
    rrcm_in_t r;
    int       mode, shape;
    coord_t   v[12];
    int       kf;
    int       zb;
    mode  = $urandom_range(0, 9);
    shape = (mode == 9) ? 2 : $urandom_range(0, 3);
    for (int i = 0; i < 12; i++) v[i] = rand_coord(shape);
    case (mode)
      5: begin  // parallel: D1 = k * D0
        kf = $signed($urandom_range(0, 6)) - 3;
        for (int i = 0; i < 3; i++) v[9+i] = rand_coord(1) * kf;
        for (int i = 0; i < 3; i++) v[3+i] = v[9+i];
        if (kf == 0) kf = 2;
        for (int i = 0; i < 3; i++) v[9+i] = v[3+i] * kf;
      end
      6, 7: begin  // nearly parallel: tiny tilt on the second direction
        for (int i = 0; i < 3; i++)
          v[9+i] = v[3+i] + coord_t'($signed($urandom_range(0, 4)) - 2);
      end
      8: begin  // one zero-length direction
        zb = $urandom_range(0, 1) ? 3 : 9;
        for (int i = 0; i < 3; i++) v[zb + i] = '0;
      end
      default: ;
    endcase
    r = make_rays(v[0], v[1], v[2], v[3], v[4], v[5],
                  v[6], v[7], v[8], v[9], v[10], v[11]);
    return r;
  endfunction

  // Directed table: rays plus a hand-typed result where one is obvious.
  typedef struct {
    rrcm_in_t  rays;
    bit        typed;
    rrcm_out_t want;
  } ray_row_t;

  ray_row_t rows[$];

  task automatic add_row(rrcm_in_t r, bit typed, rrcm_out_t want);
    ray_row_t row;
    row.rays = r; row.typed = typed; row.want = want;
    rows.push_back(row);
  endtask

  task automatic build_rows();
    rrcm_out_t par;
    par = '{mid_x: '0, mid_y: '0, mid_z: '0, lines_parallel: 1'b1};
    // all zero: both directions empty
    add_row('0, 1'b1, par);
    // first direction zero-length
    add_row(make_rays(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0, ONE, 0, 0), 1'b1, par);
    // second direction zero-length
    add_row(make_rays(0, 0, 0, 0, ONE, 0, ONE, 0, 0, 0, 0, 0), 1'b1, par);
    // same and opposite direction: parallel
    add_row(make_rays(0, 0, 0, ONE, ONE, 0, ONE, 0, 0, 2 * ONE, 2 * ONE, 0), 1'b1, par);
    add_row(make_rays(5, 6, 7, CMAX, 0, 0, 1, 2, 3, -CMAX, 0, 0), 1'b1, par);
    add_row(make_rays(0, 0, 0, CMIN, CMIN, CMIN, 0, 0, 0, CMIN, CMIN, CMIN), 1'b1, par);
    // x axis and a y line at z = 2: midpoint (0, 0, 1)
    add_row(make_rays(0, 0, 0, ONE, 0, 0, 0, 0, 2 * ONE, 0, ONE, 0), 1'b1,
            '{mid_x: '0, mid_y: '0, mid_z: ONE, lines_parallel: 1'b0});
    // z gap of one LSB: exact half, rounds up
    add_row(make_rays(0, 0, 0, ONE, 0, 0, 0, 0, 1, 0, ONE, 0), 1'b1,
            '{mid_x: '0, mid_y: '0, mid_z: 1, lines_parallel: 1'b0});
    // negative half rounds toward plus infinity
    add_row(make_rays(0, 0, 0, ONE, 0, 0, 0, 0, -1, 0, ONE, 0), 1'b1,
            '{mid_x: '0, mid_y: '0, mid_z: '0, lines_parallel: 1'b0});
    // origins at the top and bottom of the range
    add_row(make_rays(CMAX, CMAX, CMAX, 0, ONE, 0, CMAX, CMAX, CMAX, 0, 0, ONE), 1'b1,
            '{mid_x: CMAX, mid_y: CMAX, mid_z: CMAX, lines_parallel: 1'b0});
    add_row(make_rays(CMIN, CMIN, CMIN, 0, ONE, 0, CMIN, CMIN, CMIN, 0, 0, ONE), 1'b1,
            '{mid_x: CMIN, mid_y: CMIN, mid_z: CMIN, lines_parallel: 1'b0});
    // extremes mixed, left to the predictor
    add_row(make_rays(CMAX, CMIN, CMAX, CMIN, CMAX, 1, CMIN, CMAX, CMIN, CMAX, 1, CMIN),
            1'b0, '0);
    add_row(make_rays(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN),
            1'b0, '0);
    add_row(make_rays('1, '1, '1, '1, 0, '1, 0, '1, 0, 1, '1, 1), 1'b0, '0);
    // near-parallel with far-apart origins: saturates
    add_row(make_rays(CMAX, 0, CMIN, CMAX, CMAX, 0, CMIN, 0, CMAX, CMAX, CMAX - 1, 0),
            1'b0, '0);
    add_row(make_rays(CMIN, CMAX, 0, ONE, ONE, ONE, CMAX, CMIN, 0, ONE, ONE, ONE + 1),
            1'b0, '0);
    // skew lines with fractions
    add_row(make_rays(32'sh0001_8000, -32'sh0002_4000, 32'sh0000_0003,
                      32'sh0000_c000, 32'sh0001_0000, -32'sh0000_2000,
                      -32'sh0003_0000, 32'sh0000_0001, 32'sh0004_8000,
                      -32'sh0001_0000, 32'sh0000_4000, 32'sh0002_0000), 1'b0, '0);
  endtask

  // Result checker: done is a one-cycle strobe, sampled at the rising edge.
  always @(posedge clk) begin
    rrcm_out_t want;
    if (!rst && done) begin
      if (midpoints_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, actual %h", $realtime, result);
      end else begin
        want = midpoints_due.pop_front();
        if (result.mid_x !== want.mid_x) begin
          mismatch_count++;
          $display("%0t: mid_x expected %h actual %h", $realtime, want.mid_x, result.mid_x);
        end
        if (result.mid_y !== want.mid_y) begin
          mismatch_count++;
          $display("%0t: mid_y expected %h actual %h", $realtime, want.mid_y, result.mid_y);
        end
        if (result.mid_z !== want.mid_z) begin
          mismatch_count++;
          $display("%0t: mid_z expected %h actual %h", $realtime, want.mid_z, result.mid_z);
        end
        if (result.lines_parallel !== want.lines_parallel) begin
          mismatch_count++;
          $display("%0t: lines_parallel expected %b actual %b", $realtime,
                   want.lines_parallel, result.lines_parallel);
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rrcm_in_t r;
    build_rows();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, with the odd gap so the pipe sees bubbles
    foreach (rows[i]) begin
      if ($urandom_range(0, 3) == 0) idle_burst();
      send_rays(rows[i].rays,
                rows[i].typed ? rows[i].want : closest_midpoint(rows[i].rays));
    end

    // random part; gaps come in bursts, none in the tail
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 4) == 0) idle_burst();
      r = random_rays();
      send_rays(r, closest_midpoint(r));
    end
    start <= 1'b0;

    while (midpoints_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rrcm_pkg.sv
rtl/core/rrcm_mul.sv
rtl/core/ray_ray_closest_midpoint.sv
test/tb_top.sv
